// ----- hw/rtl/bsc_pkg.sv -----
// Package for the barometric sensor compensation block.
// Holds field widths, register indexes and the fixed scheme constants.
// No dependencies.
`default_nettype none
package bsc_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivW   = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCoeffA = 2'd0,
    CfgCoeffB = 2'd1,
    CfgCoeffC = 2'd2
  } cfg_idx_e;

  localparam logic [WordW-1:0] KTempOffs  = 32'd4000;
  localparam logic [WordW-1:0] KHalfScale = 32'd32768;
  localparam logic [WordW-1:0] KPressMul  = 32'd50000;
  localparam logic [WordW-1:0] KCorrA     = 32'd3038;
  localparam logic [WordW-1:0] KCorrB     = 32'hFFFF_E343;
  localparam logic [WordW-1:0] KCorrC     = 32'd3791;

endpackage
`default_nettype wire

// ----- hw/rtl/bsc_in_if.sv -----
// Input channel of the compensation block: one pair of raw readings.
// Depends on bsc_pkg.
`default_nettype none
interface bsc_in_if;
  import bsc_pkg::*;
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_temp;
  logic [RawW-1:0] raw_press;
  modport source (output valid, output raw_temp, output raw_press, input ready);
  modport sink (input valid, input raw_temp, input raw_press, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bsc_out_if.sv -----
// Output channel of the compensation block: one compensated result.
// Depends on bsc_pkg.
`default_nettype none
interface bsc_out_if;
  import bsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] temp_tenths;
  logic [WordW-1:0] press_pa;
  logic             div_error;
  modport source (output valid, output temp_tenths, output press_pa, output div_error,
                  input ready);
  modport sink (input valid, input temp_tenths, input press_pa, input div_error,
                output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/baro_sensor_compensation.sv -----
// Barometric sensor compensation, temperature and pressure at oversampling 0.
// One pair is taken per cycle while the output is not stalled.
// The two 32-stage divider pipelines set most of the latency.
// A stalled output freezes the whole pipeline; input ready follows it.
// Reset clears all valid bits and the coefficient registers to zero.
`default_nettype none
module baro_sensor_compensation (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bsc_pkg::CfgW-1:0]     cfg_data_i,
  bsc_in_if.sink                            in_i,
  bsc_out_if.source                         out_o
);
  import bsc_pkg::*;

  function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] v, input int unsigned s);
    return WordW'($signed(v) >>> s);
  endfunction

  function automatic logic [WordW-1:0] sx(input logic [RawW-1:0] v);
    return {{(WordW-RawW){v[RawW-1]}}, v};
  endfunction

  logic [CfgW-1:0]  coeff_a_q, coeff_b_q;
  logic [WordW-1:0] coeff_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_a_q <= '0;
      coeff_b_q <= '0;
      coeff_c_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCoeffA: coeff_a_q <= cfg_data_i;
        CfgCoeffB: coeff_b_q <= cfg_data_i;
        CfgCoeffC: coeff_c_q <= cfg_data_i[WordW-1:0];
        default: ;
      endcase
    end
  end

  logic [WordW-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx(coeff_a_q[15:0]);
  assign ac2 = sx(coeff_a_q[31:16]);
  assign ac3 = sx(coeff_a_q[47:32]);
  assign ac4 = {16'd0, coeff_a_q[63:48]};
  assign ac5 = {16'd0, coeff_b_q[15:0]};
  assign ac6 = {16'd0, coeff_b_q[31:16]};
  assign b1  = sx(coeff_b_q[47:32]);
  assign b2  = sx(coeff_b_q[63:48]);
  assign mc  = sx(coeff_c_q[15:0]);
  assign md  = sx(coeff_c_q[31:16]);

  logic adv;
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // Front stages.
  logic             va_q, vb_q, vc_q;
  logic [WordW-1:0] a_diff_q, b_prod_q;
  logic [RawW-1:0]  a_up_q, b_up_q, c_up_q;
  logic [WordW-1:0] c_x1_q, c_ma_q, c_mb_q;
  logic             c_sign_q, c_dz_q;

  logic [WordW-1:0] c_x1_d, c_den_d, c_num_d;
  assign c_x1_d  = asr(b_prod_q, 15);
  assign c_den_d = c_x1_d + md;
  assign c_num_d = mc << 11;

  // Temperature divider.
  localparam int unsigned TSideW = WordW + RawW + 2;
  logic              vt;
  logic [WordW-1:0]  t_q;
  logic [TSideW-1:0] t_side;
  logic [WordW-1:0]  t_x1;
  logic [RawW-1:0]   t_up;
  logic              t_sign, t_dz;
  assign {t_x1, t_up, t_sign, t_dz} = t_side;

  bsc_udiv_pipe #(.W(DivW), .SW(TSideW)) u_tdiv (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(vc_q),
    .dividend_i(c_ma_q), .divisor_i(c_mb_q),
    .side_i({c_x1_q, c_up_q, c_sign_q, c_dz_q}),
    .valid_o(vt), .quot_o(t_q), .side_o(t_side)
  );

  logic [WordW-1:0] d_x2, d_b5;
  assign d_x2 = t_sign ? (WordW'(0) - t_q) : t_q;
  assign d_b5 = t_x1 + d_x2;

  logic             vd_q, ve_q, vf_q, vg_q, vh_q, vi_q, vj_q, vk_q;
  logic [WordW-1:0] d_temp_q, d_b6_q;
  logic [RawW-1:0]  d_up_q, e_up_q, f_up_q, g_up_q, h_up_q, i_up_q;
  logic             d_dz_q, e_dz_q, f_dz_q, g_dz_q, h_dz_q, i_dz_q, j_dz_q, k_dz_q;
  logic [WordW-1:0] e_temp_q, f_temp_q, g_temp_q, h_temp_q, i_temp_q, j_temp_q, k_temp_q;
  logic [WordW-1:0] e_sqp_q, e_ac2b6_q, e_ac3b6_q;
  logic [WordW-1:0] f_sq_q, f_ac2b6_q, f_ac3b6_q;
  logic [WordW-1:0] g_b2sq_q, g_b1sq_q, g_ac2b6_q, g_ac3b6_q;
  logic [WordW-1:0] h_b3_q, h_x3_q;
  logic [WordW-1:0] i_m4_q, i_dup_q;
  logic [WordW-1:0] j_b4_q, j_b7_q;
  logic [WordW-1:0] k_dvd_q, k_b4_q;
  logic             k_shq_q, k_bz_q;

  logic [WordW-1:0] h_x3a, h_x1b;
  assign h_x3a = asr(g_b2sq_q, 11) + asr(g_ac2b6_q, 11);
  assign h_x1b = asr(g_ac3b6_q, 13) + asr(g_b1sq_q, 16);

  // Pressure divider.
  localparam int unsigned PSideW = WordW + 3;
  logic              vp;
  logic [WordW-1:0]  p_q;
  logic [PSideW-1:0] p_side;
  logic [WordW-1:0]  p_temp;
  logic              p_dz, p_bz, p_shq;
  assign {p_temp, p_dz, p_bz, p_shq} = p_side;

  bsc_udiv_pipe #(.W(DivW), .SW(PSideW)) u_pdiv (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(vk_q),
    .dividend_i(k_dvd_q), .divisor_i(k_b4_q),
    .side_i({k_temp_q, k_dz_q, k_bz_q, k_shq_q}),
    .valid_o(vp), .quot_o(p_q), .side_o(p_side)
  );

  logic             vl_q, vm_q, vn_q, vo_q;
  logic [WordW-1:0] l_p_q, l_temp_q, m_p_q, m_temp_q, n_p_q, n_temp_q;
  logic             l_dz_q, l_bz_q, m_dz_q, m_bz_q, n_dz_q, n_bz_q;
  logic [WordW-1:0] m_m1_q, m_m2_q, n_m3_q, n_m2_q;
  logic [WordW-1:0] o_temp_q, o_press_q;
  logic             o_err_q;

  logic [WordW-1:0] m_a, o_pf;
  assign m_a  = asr(l_p_q, 8);
  assign o_pf = n_p_q + asr(asr(n_m3_q, 16) + asr(n_m2_q, 16) + KCorrC, 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q, vi_q, vj_q, vk_q} <= '0;
      {vl_q, vm_q, vn_q, vo_q} <= '0;
    end else if (adv) begin
      va_q <= in_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vt;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
      vi_q <= vh_q;
      vj_q <= vi_q;
      vk_q <= vj_q;
      vl_q <= vp;
      vm_q <= vl_q;
      vn_q <= vm_q;
      vo_q <= vn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_diff_q  <= {16'd0, in_i.raw_temp} - ac6;
      a_up_q    <= in_i.raw_press;
      b_prod_q  <= a_diff_q * ac5;
      b_up_q    <= a_up_q;
      c_x1_q    <= c_x1_d;
      c_up_q    <= b_up_q;
      c_ma_q    <= c_num_d[WordW-1] ? (WordW'(0) - c_num_d) : c_num_d;
      c_mb_q    <= c_den_d[WordW-1] ? (WordW'(0) - c_den_d) : c_den_d;
      c_sign_q  <= c_num_d[WordW-1] ^ c_den_d[WordW-1];
      c_dz_q    <= (c_den_d == '0);

      d_temp_q  <= asr(d_b5 + WordW'(8), 4);
      d_b6_q    <= d_b5 - KTempOffs;
      d_up_q    <= t_up;
      d_dz_q    <= t_dz;

      e_sqp_q   <= d_b6_q * d_b6_q;
      e_ac2b6_q <= ac2 * d_b6_q;
      e_ac3b6_q <= ac3 * d_b6_q;
      e_temp_q  <= d_temp_q;
      e_up_q    <= d_up_q;
      e_dz_q    <= d_dz_q;

      f_sq_q    <= asr(e_sqp_q, 12);
      f_ac2b6_q <= e_ac2b6_q;
      f_ac3b6_q <= e_ac3b6_q;
      f_temp_q  <= e_temp_q;
      f_up_q    <= e_up_q;
      f_dz_q    <= e_dz_q;

      g_b2sq_q  <= b2 * f_sq_q;
      g_b1sq_q  <= b1 * f_sq_q;
      g_ac2b6_q <= f_ac2b6_q;
      g_ac3b6_q <= f_ac3b6_q;
      g_temp_q  <= f_temp_q;
      g_up_q    <= f_up_q;
      g_dz_q    <= f_dz_q;

      h_b3_q    <= asr((ac1 << 2) + h_x3a + WordW'(2), 2);
      h_x3_q    <= asr(h_x1b + WordW'(2), 2);
      h_temp_q  <= g_temp_q;
      h_up_q    <= g_up_q;
      h_dz_q    <= g_dz_q;

      i_m4_q    <= ac4 * (h_x3_q + KHalfScale);
      i_dup_q   <= {16'd0, h_up_q} - h_b3_q;
      i_temp_q  <= h_temp_q;
      i_dz_q    <= h_dz_q;

      j_b4_q    <= i_m4_q >> 15;
      j_b7_q    <= i_dup_q * KPressMul;
      j_temp_q  <= i_temp_q;
      j_dz_q    <= i_dz_q;

      k_dvd_q   <= j_b7_q[WordW-1] ? j_b7_q : (j_b7_q << 1);
      k_shq_q   <= j_b7_q[WordW-1];
      k_b4_q    <= j_b4_q;
      k_bz_q    <= (j_b4_q == '0);
      k_temp_q  <= j_temp_q;
      k_dz_q    <= j_dz_q;

      l_p_q     <= p_shq ? (p_q << 1) : p_q;
      l_temp_q  <= p_temp;
      l_dz_q    <= p_dz;
      l_bz_q    <= p_bz;

      m_m1_q    <= m_a * m_a;
      m_m2_q    <= KCorrB * l_p_q;
      m_p_q     <= l_p_q;
      m_temp_q  <= l_temp_q;
      m_dz_q    <= l_dz_q;
      m_bz_q    <= l_bz_q;

      n_m3_q    <= m_m1_q * KCorrA;
      n_m2_q    <= m_m2_q;
      n_p_q     <= m_p_q;
      n_temp_q  <= m_temp_q;
      n_dz_q    <= m_dz_q;
      n_bz_q    <= m_bz_q;

      o_temp_q  <= n_dz_q ? '0 : n_temp_q;
      o_press_q <= (n_dz_q || n_bz_q) ? '0 : o_pf;
      o_err_q   <= n_dz_q || n_bz_q;
    end
  end

  assign out_o.valid       = vo_q;
  assign out_o.temp_tenths = o_temp_q;
  assign out_o.press_pa    = o_press_q;
  assign out_o.div_error   = o_err_q;

  a_err_press_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.div_error |-> out_o.press_pa == '0)
    else $error("pressure not forced to zero on a divide error");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == !(out_o.valid && !out_o.ready))
    else $error("input ready does not follow the output stall");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vn_q) && $stable(vl_q) && $stable(vd_q))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

// ----- hw/rtl/bsc_udiv_pipe.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a sideband word alongside each item. Depends on nothing.
`default_nettype none
module bsc_udiv_pipe #(
  parameter int unsigned W  = 32,
  parameter int unsigned SW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [W-1:0]  dividend_i,
  input  wire logic [W-1:0]  divisor_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [W-1:0]       quot_o,
  output logic [SW-1:0]      side_o
);

  logic [W-1:0]  rem_q  [W];
  logic [W-1:0]  dvd_q  [W];
  logic [W-1:0]  dsr_q  [W];
  logic [SW-1:0] side_q [W];
  logic [W-1:0]  vld_q;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]  rem_in, dvd_in, dsr_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [W:0]    trial;
    logic          qbit;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign dvd_in  = dividend_i;
      assign dsr_in  = divisor_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign dvd_in  = dvd_q[k-1];
      assign dsr_in  = dsr_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = {rem_in, dvd_in[W-1]};
    assign qbit  = (trial >= {1'b0, dsr_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= qbit ? W'(trial - {1'b0, dsr_in}) : trial[W-1:0];
        dvd_q[k]  <= {dvd_in[W-2:0], qbit};
        dsr_q[k]  <= dsr_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign quot_o  = dvd_q[W-1];
  assign side_o  = side_q[W-1];

endmodule
`default_nettype wire

// ----- bench/tb_baro_sensor_compensation.sv -----
// Self-checking testbench for the barometric sensor compensation block.
// Predicts each result in place and compares every output transfer with it.
// Depends on bsc_pkg, bsc_in_if, bsc_out_if and baro_sensor_compensation.
`default_nettype none
module tb_baro_sensor_compensation;
  import bsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WordW-1:0] temp_tenths;
    logic [WordW-1:0] press_pa;
    logic             div_error;
  } comp_res_t;

  localparam int unsigned LatencyCycles = 79;
  localparam int unsigned IdleLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgCoeffA;
  logic [CfgW-1:0] cfg_data_i = '0;

  bsc_in_if in_ch ();
  bsc_out_if out_ch ();

  baro_sensor_compensation u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  logic [63:0] coeff_a, coeff_b;
  logic [31:0] coeff_c;
  comp_res_t   pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned error_results = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_off = 0;
  bit          sink_random = 1'b1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.raw_temp = '0;
    in_ch.raw_press = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic comp_res_t compensate(input logic [15:0] ut16, input logic [15:0] up16);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, p, den, t;
    comp_res_t r;
    ac1 = sx16(coeff_a[15:0]);  ac2 = sx16(coeff_a[31:16]);
    ac3 = sx16(coeff_a[47:32]); ac4 = {16'd0, coeff_a[63:48]};
    ac5 = {16'd0, coeff_b[15:0]}; ac6 = {16'd0, coeff_b[31:16]};
    b1 = sx16(coeff_b[47:32]);  b2 = sx16(coeff_b[63:48]);
    mc = sx16(coeff_c[15:0]);   md = sx16(coeff_c[31:16]);
    ut = {16'd0, ut16};
    up = {16'd0, up16};
    r = '0;
    x1 = asr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.div_error = 1'b1;
      return r;
    end
    x2 = quot_trunc(mc << 11, den);
    b5 = x1 + x2;
    t = asr(b5 + 32'd8, 4);
    r.temp_tenths = t;
    b6 = b5 - KTempOffs;
    sq = asr(b6 * b6, 12);
    x1 = asr(b2 * sq, 11);
    x2 = asr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = asr(ac1 * 32'd4 + x3 + 32'd2, 2);
    x1 = asr(ac3 * b6, 13);
    x2 = asr(b1 * sq, 16);
    x3 = asr(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + KHalfScale)) >> 15;
    if (b4 == 0) begin
      r.div_error = 1'b1;
      return r;
    end
    b7 = (up - b3) * KPressMul;
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = asr(p, 8) * asr(p, 8);
    x1 = asr(x1 * KCorrA, 16);
    x2 = asr(KCorrB * p, 16);
    r.press_pa = p + asr(x1 + x2 + KCorrC, 4);
    return r;
  endfunction

  task automatic write_coeff(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgCoeffA: coeff_a = value;
      CfgCoeffB: coeff_b = value;
      CfgCoeffC: coeff_c = value[31:0];
      default: ;
    endcase
  endtask

  task automatic set_coeffs(input logic [63:0] a, input logic [63:0] b, input logic [31:0] c);
    write_coeff(CfgCoeffA, a);
    write_coeff(CfgCoeffB, b);
    write_coeff(CfgCoeffC, {32'd0, c});
  endtask

  // Sends one reading pair, waiting a random gap first unless gap is disabled.
  // Valid stays high afterwards; a gap or drain() takes it low.
  task automatic send_pair(input logic [15:0] ut, input logic [15:0] up, input bit gap = 1'b1);
    int unsigned wait_n;
    wait_n = gap ? $urandom_range(0, 5) : 0;
    if (wait_n != 0) begin
      in_ch.valid <= 1'b0;
      repeat (wait_n) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_temp <= ut;
    in_ch.raw_press <= up;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(compensate(ut, up));
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (LatencyCycles + 10) @(negedge clk_i);
  endtask

  // Sink side: a random stall per result, a long hold-off when requested, or always ready otherwise.
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      if (hold_off != 0) begin
        out_ch.ready <= 1'b0;
        hold_off--;
      end else if (sink_random) begin
        stall = $urandom_range(0, 5);
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        out_ch.ready <= 1'b1;
        do @(posedge clk_i); while (!out_ch.valid);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    comp_res_t expd;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (out_ch.div_error) error_results++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result transfer at %0t", $realtime);
      end else begin
        expd = pending_results.pop_front();
        if (out_ch.temp_tenths !== expd.temp_tenths || out_ch.press_pa !== expd.press_pa ||
            out_ch.div_error !== expd.div_error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: temp %0d/%0d press %0d/%0d err %0b/%0b (exp/act)",
                     $signed(expd.temp_tenths), $signed(out_ch.temp_tenths),
                     $signed(expd.press_pa), $signed(out_ch.press_pa),
                     expd.div_error, out_ch.div_error);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        pending_results.size() == 0 && !in_ch.valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired with %0d results outstanding", pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  localparam logic [63:0] TypA = {16'd32741, 16'hFFC9, 16'hFB93, 16'd408};
  localparam logic [63:0] TypB = {16'hFF80, 16'd4, 16'd23153, 16'd32757};
  localparam logic [31:0] TypC = {16'd2868, 16'hD4BD};

  task automatic test_reset_coeffs;
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    drain();
  endtask

  task automatic test_typical_extremes;
    set_coeffs(TypA, TypB, TypC);
    send_pair(16'd27898, 16'd23843);
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'hAAAA, 16'h5555);
    drain();
  endtask

  task automatic test_div_errors;
    // Temperature divisor zero: AC5 zero makes X1 zero, and MD is zero.
    set_coeffs(TypA, {TypB[63:16], 16'd0}, {16'd0, TypC[15:0]});
    send_pair(16'd1234, 16'd40000);
    drain();
    // Pressure divisor zero: AC4 zero.
    set_coeffs({16'd0, TypA[47:0]}, TypB, TypC);
    send_pair(16'd27898, 16'd23843);
    send_pair(16'hFFFF, 16'h0000);
    drain();
    // Negative over minus one: MC = -32768 shifted gives -2^26, not the most negative
    // word; AC5 zero and MD = -1 make the divisor minus one, so the quotient is positive.
    set_coeffs(TypA, {TypB[63:16], 16'd0}, {16'hFFFF, 16'h8000});
    send_pair(16'd0, 16'd100);
    drain();
    set_coeffs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    drain();
    set_coeffs(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 32'h8000_8000);
    send_pair(16'h7FFF, 16'h8000);
    send_pair(16'h0001, 16'hFFFE);
    drain();
  endtask

  task automatic test_backpressure;
    set_coeffs(TypA, TypB, TypC);
    hold_off = 300;
    repeat (150)
      send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0);
    drain();
  endtask

  task automatic test_random(input int unsigned n_phases, input int unsigned per_phase);
    for (int ph = 0; ph < n_phases; ph++) begin
      if (ph % 3 == 0)
        set_coeffs({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      else
        set_coeffs({TypA[63:48] ^ 16'($urandom_range(0, 255)), TypA[47:0]},
                   {TypB[63:16], 16'($urandom_range(0, 65535))},
                   {16'($urandom_range(0, 4000)), 16'($urandom)});
      sink_random = (ph % 4 != 1);
      for (int i = 0; i < per_phase; i++)
        send_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  (ph % 4 != 2));
      drain();
    end
  endtask

  initial begin
    coeff_a = '0;
    coeff_b = '0;
    coeff_c = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_reset_coeffs();
    test_typical_extremes();
    test_div_errors();
    test_backpressure();
    test_random(12, 140);
    $display("Checked %0d results, %0d with the divide error flag, over %0d coefficient sets.",
             result_count, error_results, 20);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else begin
      $display("%0d mismatches", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
